[rtl/mtse_pkg.sv]
// Package for the multitouch slot event generator.
// Holds the default sizes, request and event codes used by mtse_front, mtse_back and the top level.
// Depends on nothing.
package mtse_pkg;

   localparam int FINGER_SLOTS_DEFAULT = 5;
   localparam int COORD_BITS_DEFAULT   = 16;
   localparam int QUEUE_DEPTH_DEFAULT  = 2;

   localparam int BUTTON_W    = 5;
   localparam int POS_W       = 16;
   localparam int TRACK_W     = 32;
   localparam int EVENT_VAL_W = 33;
   localparam int EVENT_KIND_W = 3;

   localparam logic [BUTTON_W-1:0] BUTTON_MAX = 5'd16;

   localparam logic REQ_BUTTON   = 1'b0;
   localparam logic REQ_POSITION = 1'b1;

   typedef enum logic [EVENT_KIND_W-1:0] {
      KIND_SLOT  = 3'd0,
      KIND_TRACK = 3'd1,
      KIND_X     = 3'd2,
      KIND_Y     = 3'd3,
      KIND_SYN   = 3'd4
   } event_kind_type;

   localparam logic [EVENT_VAL_W-1:0] TRACK_NONE = {EVENT_VAL_W{1'b1}};

endpackage

[rtl/mtse_front.sv]
// Front end of the multitouch slot event generator: takes input beats, keeps the
// finger mask and stored position, and turns each beat that causes events into a slot command.
// Depends on mtse_pkg.
module mtse_front #(
   parameter int FINGER_SLOTS = mtse_pkg::FINGER_SLOTS_DEFAULT,
   parameter int COORD_BITS   = mtse_pkg::COORD_BITS_DEFAULT,
   parameter int CMD_W        = 3 + 2 * FINGER_SLOTS + 2 * COORD_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic                          in_type,
   input  logic [mtse_pkg::BUTTON_W-1:0] in_button,
   input  logic                          in_pressed,
   input  logic [mtse_pkg::POS_W-1:0]    in_x,
   input  logic [mtse_pkg::POS_W-1:0]    in_y,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic [CMD_W-1:0]              push_data
);

   logic [FINGER_SLOTS-1:0] mask_ff, mask_in;
   logic [COORD_BITS-1:0]   x_ff, x_in;
   logic [COORD_BITS-1:0]   y_ff, y_in;

   logic                    accept;
   logic                    button_ok;
   logic [FINGER_SLOTS-1:0] button_mask;
   logic [FINGER_SLOTS-1:0] mask_next;
   logic [COORD_BITS-1:0]   x_new;
   logic [COORD_BITS-1:0]   y_new;
   logic                    dx;
   logic                    dy;
   logic                    produce;

   assign in_ready = push_ready;
   assign accept   = in_valid && in_ready;

   assign button_ok   = (in_button != '0) && (in_button <= mtse_pkg::BUTTON_MAX);
   assign button_mask = FINGER_SLOTS'(32'(in_button));
   assign mask_next   = in_pressed ? (mask_ff | button_mask) : (mask_ff & ~button_mask);

   assign x_new = COORD_BITS'(32'(in_x));
   assign y_new = COORD_BITS'(32'(in_y));
   assign dx    = x_new != x_ff;
   assign dy    = y_new != y_ff;

   always_comb begin
      mask_in   = mask_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      produce   = 1'b0;
      push_data = '0;
      if (in_type == mtse_pkg::REQ_BUTTON) begin
         produce   = button_ok && (mask_next != mask_ff);
         push_data = {1'b0, 1'b0, 1'b0, mask_next & ~mask_ff, mask_next ^ mask_ff,
                      x_ff, y_ff};
         if (accept && button_ok) begin
            mask_in = mask_next;
         end
      end else begin
         produce   = (dx || dy) && (mask_ff != '0);
         push_data = {1'b1, dx, dy, {FINGER_SLOTS{1'b0}}, mask_ff, x_new, y_new};
         if (accept) begin
            x_in = x_new;
            y_in = y_new;
         end
      end
   end

   assign push_valid = in_valid && produce;

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= '0;
         x_ff    <= '0;
         y_ff    <= '0;
      end else begin
         mask_ff <= mask_in;
         x_ff    <= x_in;
         y_ff    <= y_in;
      end
   end

endmodule

[rtl/mtse_queue.sv]
// Short command queue between the front end and the event sequencer.
// Register array with read and write pointers. Depends on nothing.
module mtse_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/mtse_back.sv]
// Event sequencer of the multitouch slot event generator: walks the slots of
// one command and emits slot, tracking id, position and sync beats.
// Depends on mtse_pkg.
module mtse_back #(
   parameter int FINGER_SLOTS = mtse_pkg::FINGER_SLOTS_DEFAULT,
   parameter int COORD_BITS   = mtse_pkg::COORD_BITS_DEFAULT,
   parameter int CMD_W        = 3 + 2 * FINGER_SLOTS + 2 * COORD_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              pop_valid,
   output logic                              pop_ready,
   input  logic [CMD_W-1:0]                  pop_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [mtse_pkg::EVENT_KIND_W-1:0] out_kind,
   output logic [mtse_pkg::EVENT_VAL_W-1:0]  out_value,
   output logic                              out_last
);

   localparam int SLOT_W = (FINGER_SLOTS > 1) ? $clog2(FINGER_SLOTS) : 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SCAN, ST_SLOT, ST_TRACK, ST_X, ST_Y, ST_SYN
   } state_type;

   state_type                          state_ff, state_in;
   logic                               is_pos_ff, is_pos_in;
   logic                               dx_ff, dx_in;
   logic                               dy_ff, dy_in;
   logic [FINGER_SLOTS-1:0]            press_ff, press_in;
   logic [FINGER_SLOTS-1:0]            pending_ff, pending_in;
   logic [COORD_BITS-1:0]              x_ff, x_in;
   logic [COORD_BITS-1:0]              y_ff, y_in;
   logic [SLOT_W-1:0]                  slot_ff, slot_in;
   logic [mtse_pkg::TRACK_W-1:0]       track_ff, track_in;
   logic                               valid_ff, valid_in;
   mtse_pkg::event_kind_type           kind_ff, kind_in;
   logic [mtse_pkg::EVENT_VAL_W-1:0]   value_ff, value_in;
   logic                               last_ff, last_in;

   logic                               advance;
   logic [FINGER_SLOTS-1:0]            slot_bit;
   logic [FINGER_SLOTS-1:0]            pending_left;

   assign advance      = !valid_ff || out_ready;
   assign pop_ready    = state_ff == ST_IDLE;
   assign slot_bit     = FINGER_SLOTS'(1) << slot_ff;
   assign pending_left = pending_ff & ~slot_bit;

   always_comb begin
      state_in   = state_ff;
      is_pos_in  = is_pos_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      press_in   = press_ff;
      pending_in = pending_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      slot_in    = slot_ff;
      track_in   = track_ff;
      valid_in   = valid_ff && !out_ready;
      kind_in    = kind_ff;
      value_in   = value_ff;
      last_in    = last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               {is_pos_in, dx_in, dy_in, press_in, pending_in, x_in, y_in} = pop_data;
               slot_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if ((pending_ff & slot_bit) != '0) begin
               state_in = ST_SLOT;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         ST_SLOT: begin
            if (advance) begin
               valid_in = 1'b1;
               kind_in  = mtse_pkg::KIND_SLOT;
               value_in = mtse_pkg::EVENT_VAL_W'(slot_ff);
               last_in  = 1'b0;
               priority if (!is_pos_ff) begin
                  state_in = ST_TRACK;
               end else if (dx_ff) begin
                  state_in = ST_X;
               end else if (dy_ff) begin
                  state_in = ST_Y;
               end else begin
                  state_in = ST_SYN;
               end
            end
         end
         ST_TRACK: begin
            if (advance) begin
               valid_in = 1'b1;
               kind_in  = mtse_pkg::KIND_TRACK;
               last_in  = 1'b0;
               if ((press_ff & slot_bit) != '0) begin
                  value_in = mtse_pkg::EVENT_VAL_W'(track_ff);
                  track_in = track_ff + 1'b1;
                  state_in = ST_X;
               end else begin
                  value_in = mtse_pkg::TRACK_NONE;
                  state_in = ST_SYN;
               end
            end
         end
         ST_X: begin
            if (advance) begin
               valid_in = 1'b1;
               kind_in  = mtse_pkg::KIND_X;
               value_in = mtse_pkg::EVENT_VAL_W'(x_ff);
               last_in  = 1'b0;
               state_in = (!is_pos_ff || dy_ff) ? ST_Y : ST_SYN;
            end
         end
         ST_Y: begin
            if (advance) begin
               valid_in = 1'b1;
               kind_in  = mtse_pkg::KIND_Y;
               value_in = mtse_pkg::EVENT_VAL_W'(y_ff);
               last_in  = 1'b0;
               state_in = ST_SYN;
            end
         end
         ST_SYN: begin
            if (advance) begin
               valid_in   = 1'b1;
               kind_in    = mtse_pkg::KIND_SYN;
               value_in   = '0;
               last_in    = pending_left == '0;
               pending_in = pending_left;
               if (pending_left == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  slot_in  = slot_ff + 1'b1;
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         track_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         track_ff <= track_in;
         valid_ff <= valid_in;
      end
      is_pos_ff  <= is_pos_in;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      press_ff   <= press_in;
      pending_ff <= pending_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      slot_ff    <= slot_in;
      kind_ff    <= kind_in;
      value_ff   <= value_in;
      last_ff    <= last_in;
   end

   assign out_valid = valid_ff;
   assign out_kind  = kind_ff;
   assign out_value = value_ff;
   assign out_last  = last_ff;

endmodule

[rtl/multitouch_slot_event_generator.sv]
// Top level of the multitouch slot event generator.
// Instantiates mtse_front, mtse_queue and mtse_back; depends on mtse_pkg.
//
// Finger button and position beats enter on the req_ side and leave as a
// stream of slot, tracking id, position and sync beats on the rsp_ side, the
// final beat of each input marked by tlast. The front end takes one input beat
// a cycle while the command queue has room; inputs that cause no events are
// absorbed there. The sequencer then loads a command, steps over each slot that
// is not concerned up to the highest slot concerned, and emits the events of
// each slot concerned in turn; it takes the next command from the queue only
// once it is back in its idle state.
module multitouch_slot_event_generator #(
   parameter int FINGER_SLOTS = mtse_pkg::FINGER_SLOTS_DEFAULT,
   parameter int COORD_BITS   = mtse_pkg::COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH  = mtse_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // button_value, pressed, pos_x, pos_y, zero fill
   input  logic        req_tuser,  // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // event_value, zero fill
   output logic [2:0]  rsp_tuser,  // event_kind
   output logic        rsp_tlast
);

   localparam int CMD_W = 3 + 2 * FINGER_SLOTS + 2 * COORD_BITS;

   logic                                push_valid;
   logic                                push_ready;
   logic [CMD_W-1:0]                    push_data;
   logic                                pop_valid;
   logic                                pop_ready;
   logic [CMD_W-1:0]                    pop_data;
   logic [mtse_pkg::EVENT_VAL_W-1:0]    event_value;

   mtse_front #(
      .FINGER_SLOTS (FINGER_SLOTS),
      .COORD_BITS   (COORD_BITS),
      .CMD_W        (CMD_W)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_type    (req_tuser),
      .in_button  (req_tdata[4:0]),
      .in_pressed (req_tdata[5]),
      .in_x       (req_tdata[21:6]),
      .in_y       (req_tdata[37:22]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   mtse_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   mtse_back #(
      .FINGER_SLOTS (FINGER_SLOTS),
      .COORD_BITS   (COORD_BITS),
      .CMD_W        (CMD_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_kind  (rsp_tuser),
      .out_value (event_value),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {7'b0, event_value};

endmodule
